/* design/gdd_pkg.sv */
// Shared types, tag codes and helpers for the GET.response decoder.
package gdd_pkg;

  localparam int STRING_CAPACITY_DEF = 64;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [8:0] BYTE_COUNT_MAX = 9'd511;

  localparam logic [7:0] RESP_TAG      = 8'hC4;
  localparam logic [7:0] KIND_NORMAL   = 8'h01;
  localparam logic [7:0] KIND_DATABLK  = 8'h02;
  localparam logic [7:0] CHOICE_DATA   = 8'h00;
  localparam logic [7:0] CHOICE_ACCERR = 8'h01;
  localparam logic [7:0] NO_ERROR_CODE = 8'hFF;

  localparam logic [7:0] T_NULL    = 8'h00;
  localparam logic [7:0] T_ARRAY   = 8'h01;
  localparam logic [7:0] T_STRUCT  = 8'h02;
  localparam logic [7:0] T_BOOL    = 8'h03;
  localparam logic [7:0] T_INT32   = 8'h05;
  localparam logic [7:0] T_UINT32  = 8'h06;
  localparam logic [7:0] T_OCTSTR  = 8'h09;
  localparam logic [7:0] T_VISSTR  = 8'h0A;
  localparam logic [7:0] T_INT8    = 8'h0F;
  localparam logic [7:0] T_INT16   = 8'h10;
  localparam logic [7:0] T_UINT8   = 8'h11;
  localparam logic [7:0] T_UINT16  = 8'h12;
  localparam logic [7:0] T_INT64   = 8'h14;
  localparam logic [7:0] T_UINT64  = 8'h15;
  localparam logic [7:0] T_ENUM    = 8'h16;
  localparam logic [7:0] T_FLOAT32 = 8'h17;
  localparam logic [7:0] T_FLOAT64 = 8'h18;

  // payload length classes; fixed widths are the byte counts themselves
  localparam logic [3:0] PL_STRING  = 4'd14;
  localparam logic [3:0] PL_UNKNOWN = 4'd15;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_PROTO   = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_ACCESS  = 3'd4;
  localparam logic [2:0] ST_UNSUP   = 3'd5;

  typedef struct packed {
    logic        is_final;
    logic [2:0]  status;
    logic [7:0]  type_tag;
    logic [63:0] value;
    logic [6:0]  string_len;
    logic [7:0]  string_byte;
    logic [7:0]  access_error;
  } res_t;

  typedef struct packed {
    logic str_vld;
    logic fin_vld;
    res_t str_res;
    res_t fin_res;
  } push_t;

  function automatic logic [3:0] payload_len(input logic [7:0] t);
    logic [3:0] w;
    case (t)
      T_NULL: w = 4'd0;
      T_ARRAY, T_STRUCT, T_BOOL, T_INT8, T_UINT8, T_ENUM: w = 4'd1;
      T_INT16, T_UINT16: w = 4'd2;
      T_INT32, T_UINT32, T_FLOAT32: w = 4'd4;
      T_INT64, T_UINT64, T_FLOAT64: w = 4'd8;
      T_OCTSTR, T_VISSTR: w = PL_STRING;
      default: w = PL_UNKNOWN;
    endcase
    return w;
  endfunction

endpackage

/* design/gdd_f32_widen.sv */
// Exact float32 to float64 bit conversion; NaNs come out quiet.
module gdd_f32_widen
  import gdd_pkg::*;
(
  input  logic [31:0] f,
  output logic [63:0] d
);

  logic        sgn;
  logic [7:0]  e;
  logic [22:0] m;
  logic [4:0]  p;
  logic [5:0]  sh;
  logic [63:0] shifted;

  assign sgn = f[31];
  assign e   = f[30:23];
  assign m   = f[22:0];

  // position of the highest set mantissa bit, for subnormals
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) p = 5'(i);
    end
  end

  assign sh      = 6'd52 - {1'b0, p};
  assign shifted = {41'd0, m} << sh;

  always_comb begin
    if (e == 8'hFF) begin
      d = {sgn, 11'h7FF, (m != 23'd0), m[21:0], 29'd0};
    end else if (e == 8'h00) begin
      if (m == 23'd0) begin
        d = {sgn, 63'd0};
      end else begin
        d = {sgn, 11'd874 + {6'd0, p}, shifted[51:0]};
      end
    end else begin
      d = {sgn, 11'd896 + {3'd0, e}, m, 29'd0};
    end
  end

endmodule

/* design/gdd_parser.sv */
// Frame parse state and per-byte result formation.
module gdd_parser
  import gdd_pkg::*;
#(
  parameter int STRING_CAPACITY = STRING_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] frame_byte,
  input  logic       frame_end,
  output push_t      push
);

  localparam logic [8:0] CAP9 = 9'(STRING_CAPACITY);
  localparam logic [7:0] CAP8 = 8'(STRING_CAPACITY);

  logic [8:0]  byte_count;
  logic [7:0]  response_kind;
  logic [7:0]  result_choice;
  logic [7:0]  item_type;
  logic [63:0] value_accum;
  logic [7:0]  declared_string_len;
  logic [7:0]  error_code;
  logic        tag_ok;

  logic [8:0]  byte_count_next;
  logic [7:0]  response_kind_next;
  logic [7:0]  result_choice_next;
  logic [7:0]  item_type_next;
  logic [63:0] value_accum_next;
  logic [7:0]  declared_string_len_next;
  logic [7:0]  error_code_next;
  logic        tag_ok_next;

  logic [63:0] f64_bits;

  gdd_f32_widen u_widen (
    .f (value_accum_next[31:0]),
    .d (f64_bits)
  );

  always_comb begin
    logic [8:0]  k;
    logic [8:0]  have;
    logic [3:0]  w;
    logic [3:0]  wn;
    logic        in_payload;
    logic [7:0]  slen;
    logic [63:0] fval;
    res_t        fin;
    res_t        str;

    byte_count_next          = (byte_count < BYTE_COUNT_MAX) ? byte_count + 9'd1 : byte_count;
    response_kind_next       = response_kind;
    result_choice_next       = result_choice;
    item_type_next           = item_type;
    value_accum_next         = value_accum;
    declared_string_len_next = declared_string_len;
    error_code_next          = error_code;
    tag_ok_next              = tag_ok;

    str = '0;
    str.string_byte  = frame_byte;
    str.access_error = NO_ERROR_CODE;
    push.str_vld = 1'b0;

    k = byte_count - 9'd5;
    w = payload_len(item_type);
    in_payload = (byte_count >= 9'd5) && (byte_count < BYTE_COUNT_MAX) && tag_ok &&
                 (response_kind == KIND_NORMAL) && (result_choice == CHOICE_DATA);

    if (byte_count == 9'd0) begin
      tag_ok_next = (frame_byte == RESP_TAG);
    end else if (byte_count == 9'd1) begin
      response_kind_next = frame_byte;
    end else if (byte_count == 9'd3) begin
      result_choice_next = frame_byte;
    end else if (byte_count == 9'd4) begin
      item_type_next  = frame_byte;
      error_code_next = frame_byte;
    end else if (in_payload) begin
      if (w == PL_STRING) begin
        if (k == 9'd0) begin
          declared_string_len_next = frame_byte;
        end else if (k <= {1'b0, declared_string_len} && (k - 9'd1) < CAP9) begin
          push.str_vld = accept;
        end
      end else if (w != PL_UNKNOWN && k < {5'd0, w}) begin
        value_accum_next = {value_accum[55:0], frame_byte};
      end
    end

    // final result, from the state as updated by this byte
    have = byte_count_next - 9'd5;
    wn   = payload_len(item_type_next);
    slen = (declared_string_len_next < CAP8) ? declared_string_len_next : CAP8;

    case (item_type_next)
      T_INT8:    fval = {{56{value_accum_next[7]}}, value_accum_next[7:0]};
      T_INT16:   fval = {{48{value_accum_next[15]}}, value_accum_next[15:0]};
      T_INT32:   fval = {{32{value_accum_next[31]}}, value_accum_next[31:0]};
      T_FLOAT32: fval = f64_bits;
      T_NULL, T_OCTSTR, T_VISSTR: fval = 64'd0;
      default:   fval = value_accum_next;
    endcase

    fin = '0;
    fin.is_final     = 1'b1;
    fin.access_error = NO_ERROR_CODE;
    if (byte_count_next < 9'd4) begin
      fin.status = ST_SHORT;
    end else if (!tag_ok_next) begin
      fin.status = ST_PROTO;
    end else if (response_kind_next == KIND_NORMAL) begin
      if (result_choice_next == CHOICE_DATA) begin
        if (byte_count_next < 9'd5) begin
          fin.status = ST_MISSING;
        end else begin
          fin.type_tag = item_type_next;
          if (wn == PL_UNKNOWN) begin
            fin.status = ST_UNSUP;
          end else if (wn == PL_STRING) begin
            if ({1'b0, have} < 10'd1 + {2'd0, declared_string_len_next}) begin
              fin.status = ST_MISSING;
            end else begin
              fin.status     = ST_OK;
              fin.string_len = slen[6:0];
            end
          end else if (have < {5'd0, wn}) begin
            fin.status = ST_MISSING;
          end else begin
            fin.status = ST_OK;
            fin.value  = fval;
          end
        end
      end else if (result_choice_next == CHOICE_ACCERR) begin
        fin.status = ST_ACCESS;
        if (byte_count_next > 9'd4) fin.access_error = error_code_next;
      end else begin
        fin.status = ST_PROTO;
      end
    end else if (response_kind_next == KIND_DATABLK) begin
      fin.status = ST_UNSUP;
    end else begin
      fin.status = ST_PROTO;
    end

    push.fin_vld = accept && frame_end;
    push.str_res = str;
    push.fin_res = fin;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && frame_end)) begin
      byte_count          <= '0;
      response_kind       <= '0;
      result_choice       <= '0;
      item_type           <= '0;
      value_accum         <= '0;
      declared_string_len <= '0;
      error_code          <= NO_ERROR_CODE;
      tag_ok              <= 1'b0;
    end else if (accept) begin
      byte_count          <= byte_count_next;
      response_kind       <= response_kind_next;
      result_choice       <= result_choice_next;
      item_type           <= item_type_next;
      value_accum         <= value_accum_next;
      declared_string_len <= declared_string_len_next;
      error_code          <= error_code_next;
      tag_ok              <= tag_ok_next;
    end
  end

endmodule

/* design/gdd_res_fifo.sv */
// Small result queue taking up to two items per cycle, one out per cycle.
module gdd_res_fifo
  import gdd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic             pop,
  output res_t             head,
  output logic [FIFO_AW:0] fill
);

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW-1:0] wr_ptr_p1;
  logic [1:0]         n_push;
  logic [FIFO_AW:0]   fill_next;

  assign wr_ptr_p1 = wr_ptr + FIFO_AW'(1);
  assign n_push    = {1'b0, push.str_vld} + {1'b0, push.fin_vld};
  assign fill_next = fill + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    // string byte goes ahead of the frame result
    if (push.str_vld && push.fin_vld) begin
      mem[wr_ptr]    <= push.str_res;
      mem[wr_ptr_p1] <= push.fin_res;
    end else if (push.str_vld) begin
      mem[wr_ptr] <= push.str_res;
    end else if (push.fin_vld) begin
      mem[wr_ptr] <= push.fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(n_push);
      if (pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      fill <= fill_next;
    end
  end

endmodule

/* design/get_response_data_decoder_top.sv */
// Each result is registered in the result queue as its causing byte is taken.
// Throughput: one frame byte per cycle unless stalled; the last byte can also
// carry a string byte and then yields two results, drained one per cycle on
// out_ready from a four-entry result queue that stalls input unless two are free.
// Reset: synchronous, clears the parse state and empties the result queue.
module get_response_data_decoder_top
  import gdd_pkg::*;
#(
  parameter int STRING_CAPACITY = STRING_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_final,
  output logic [2:0]  status,
  output logic [7:0]  type_tag,
  output logic [63:0] value,
  output logic [6:0]  string_len,
  output logic [7:0]  string_byte,
  output logic [7:0]  access_error
);

  push_t            push;
  res_t             head;
  logic [FIFO_AW:0] fill;
  logic             accept;

  assign in_ready  = (fill <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign accept    = in_valid && in_ready;
  assign out_valid = (fill != '0);

  gdd_parser #(
    .STRING_CAPACITY (STRING_CAPACITY)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .push       (push)
  );

  gdd_res_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (out_valid && out_ready),
    .head (head),
    .fill (fill)
  );

  assign is_final     = head.is_final;
  assign status       = head.status;
  assign type_tag     = head.type_tag;
  assign value        = head.value;
  assign string_len   = head.string_len;
  assign string_byte  = head.string_byte;
  assign access_error = head.access_error;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> out_valid)
    else $error("frame end produced no result");

  a_string_fixed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_final |-> status == ST_OK && access_error == NO_ERROR_CODE &&
    value == 64'd0)
    else $error("string byte result carries frame fields");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty queue");

endmodule
